// ----- hdl/nmea_value_sentence_parser_core_defines.svh -----
// Assertion helpers for the top RTL file of the sentence parser.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef NMEA_VALUE_SENTENCE_PARSER_CORE_DEFINES_SVH
`define NMEA_VALUE_SENTENCE_PARSER_CORE_DEFINES_SVH

`define NVSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define NVSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/nvsp_pkg.sv -----
`timescale 1ns / 1ps

package nvsp_pkg;

  localparam int HdrLen = 7;
  localparam int MagW   = 16;
  localparam logic [MagW-1:0] MagMax = '1;

  typedef logic [1:0] kind_t;
  localparam kind_t KindHdt  = 2'd0;
  localparam kind_t KindPsag = 2'd1;
  localparam kind_t KindVbw  = 2'd2;
  localparam kind_t KindNone = 2'd3;

  // Per-character control from the framing checker to the field converter.
  typedef struct packed {
    logic res;
    logic at_field;
  } step_info_t;

  typedef struct packed {
    kind_t kind;
    logic  frame_ok;
  } frame_sts_t;

  typedef struct packed {
    logic            field_ok;
    logic            is_neg;
    logic [1:0]      frac_count;
    logic [MagW-1:0] magnitude;
    logic            round_carry;
  } field_sts_t;

  function automatic logic [7:0] hdr_char(kind_t k, logic [2:0] i);
    logic [55:0] s;
    case (k)
      KindHdt:  s = "$INHDT,";
      KindPsag: s = "$PSAG1,";
      KindVbw:  s = "$VMVBW,";
      default:  s = '0;
    endcase
    return s[8*(6 - int'(i)) +: 8];
  endfunction

  function automatic logic res_of(kind_t k);
    return (k == KindPsag) || (k == KindVbw);
  endfunction

  function automatic logic sign_of(kind_t k);
    return (k == KindPsag) || (k == KindVbw);
  endfunction

  function automatic logic [9:0] max_of(kind_t k);
    return (k == KindHdt) ? 10'd359 : 10'd999;
  endfunction

  function automatic logic [7:0] len_max_of(kind_t k);
    logic [7:0] n;
    case (k)
      KindHdt:  n = 8'd21;
      KindPsag: n = 8'd17;
      KindVbw:  n = 8'd31;
      default:  n = 8'd0;
    endcase
    return n;
  endfunction

  // Appends one decimal digit, saturating at the top of the magnitude range.
  function automatic logic [MagW-1:0] mag_push(logic [MagW-1:0] m, logic [3:0] d);
    logic [MagW+3:0] r;
    r = ({4'b0, m} << 3) + ({4'b0, m} << 1) + {{MagW{1'b0}}, d};
    return (r > {4'b0, MagMax}) ? MagMax : r[MagW-1:0];
  endfunction

endpackage

// ----- hdl/nvsp_if.sv -----
`timescale 1ns / 1ps

interface nvsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic [1:0] msg_type;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, msg_byte, msg_type, first_byte, last_byte, input ready);
  modport sink (input valid, msg_byte, msg_type, first_byte, last_byte, output ready);
endinterface

interface nvsp_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic signed [10:0] value;
  logic               resolution;
  logic               print_sign;

  modport source (output valid, valid_res, value, resolution, print_sign, input ready);
  modport sink (input valid, valid_res, value, resolution, print_sign, output ready);
endinterface

// ----- hdl/nvsp_frame_chk.sv -----
`timescale 1ns / 1ps

module nvsp_frame_chk (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  logic [1:0]             type_i,
  input  logic                   first_i,
  output nvsp_pkg::step_info_t   info_o,
  output nvsp_pkg::frame_sts_t   sts_o
);

  localparam logic [2:0] SpWait = 3'd0;
  localparam logic [2:0] SpAcc  = 3'd1;
  localparam logic [2:0] SpHex1 = 3'd2;
  localparam logic [2:0] SpHex2 = 3'd3;
  localparam logic [2:0] SpDone = 3'd4;
  localparam logic [2:0] SpFail = 3'd5;

  nvsp_pkg::kind_t kind_q, kind_d, kind_cur;
  logic [7:0]  cnt_q, cnt_d, cnt_cur;
  logic        hm_q, hm_d, hm_cur;
  logic [15:0] recent_q, recent_d, recent_cur;
  logic        tail_q, tail_d, tail_cur;
  logic [2:0]  sp_q, sp_d, sp_cur;
  logic [7:0]  xor_q, xor_d, xor_cur;
  logic [7:0]  sent_q, sent_d, sent_cur;
  logic        tail_hit;
  logic [4:0]  hex;

  // Bit 4 flags a legal hex digit of either case.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] h;
    if (c >= "0" && c <= "9") begin
      h = {1'b1, c[3:0]};
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      h = {1'b1, c[3:0] + 4'd9};
    end else begin
      h = 5'd0;
    end
    return h;
  endfunction

  always_comb begin
    // A first character starts from the cleared state.
    kind_cur   = first_i ? type_i : kind_q;
    cnt_cur    = first_i ? 8'd0 : cnt_q;
    hm_cur     = first_i ? 1'b1 : hm_q;
    recent_cur = first_i ? 16'd0 : recent_q;
    tail_cur   = first_i ? 1'b0 : tail_q;
    sp_cur     = first_i ? SpWait : sp_q;
    xor_cur    = first_i ? 8'd0 : xor_q;
    sent_cur   = first_i ? 8'd0 : sent_q;

    kind_d   = kind_cur;
    hm_d     = hm_cur;
    tail_d   = tail_cur;
    sp_d     = sp_cur;
    xor_d    = xor_cur;
    sent_d   = sent_cur;
    hex      = hex_val(byte_i);

    case (kind_cur)
      nvsp_pkg::KindHdt: begin
        tail_hit = byte_i == "*" && recent_cur[7:0] == "T" && recent_cur[15:8] == ",";
      end
      nvsp_pkg::KindPsag: begin
        tail_hit = byte_i == "*";
      end
      nvsp_pkg::KindVbw: begin
        tail_hit = byte_i == "*" && recent_cur[7:0] == "V" && recent_cur[15:8] == ",";
      end
      default: begin
        tail_hit = 1'b0;
      end
    endcase

    if (kind_cur != nvsp_pkg::KindNone) begin
      if (cnt_cur < 8'(nvsp_pkg::HdrLen) &&
          byte_i != nvsp_pkg::hdr_char(kind_cur, cnt_cur[2:0])) begin
        hm_d = 1'b0;
      end
      if (tail_hit) begin
        tail_d = 1'b1;
      end
    end

    case (sp_cur)
      SpWait: begin
        if (byte_i == "$") sp_d = SpAcc;
      end
      SpAcc: begin
        if (byte_i == "*") begin
          sp_d = SpHex1;
        end else begin
          xor_d = xor_cur ^ byte_i;
        end
      end
      SpHex1: begin
        if (!hex[4]) begin
          sp_d = SpFail;
        end else begin
          sent_d = {hex[3:0], 4'd0};
          sp_d   = SpHex2;
        end
      end
      SpHex2: begin
        if (!hex[4]) begin
          sp_d = SpFail;
        end else begin
          sent_d = {sent_cur[7:4], hex[3:0]};
          sp_d   = SpDone;
        end
      end
      default: begin
      end
    endcase

    cnt_d    = (cnt_cur != 8'hFF) ? cnt_cur + 8'd1 : cnt_cur;
    recent_d = {recent_cur[7:0], byte_i};
  end

  assign info_o.res      = nvsp_pkg::res_of(kind_cur);
  assign info_o.at_field = cnt_cur == 8'(nvsp_pkg::HdrLen);

  assign sts_o.kind     = kind_q;
  assign sts_o.frame_ok = kind_q != nvsp_pkg::KindNone && sp_q == SpDone &&
                          xor_q == sent_q && hm_q && tail_q &&
                          cnt_q <= nvsp_pkg::len_max_of(kind_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= nvsp_pkg::KindHdt;
      cnt_q    <= 8'd0;
      hm_q     <= 1'b1;
      recent_q <= 16'd0;
      tail_q   <= 1'b0;
      sp_q     <= SpWait;
      xor_q    <= 8'd0;
      sent_q   <= 8'd0;
    end else if (step_i) begin
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      hm_q     <= hm_d;
      recent_q <= recent_d;
      tail_q   <= tail_d;
      sp_q     <= sp_d;
      xor_q    <= xor_d;
      sent_q   <= sent_d;
    end
  end

endmodule

// ----- hdl/nvsp_field_conv.sv -----
`timescale 1ns / 1ps

module nvsp_field_conv #(
  parameter int FIELD_CHARS = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 first_i,
  input  logic [7:0]           byte_i,
  input  nvsp_pkg::step_info_t info_i,
  output nvsp_pkg::field_sts_t sts_o
);

  localparam int LenW = $clog2(FIELD_CHARS + 1);

  localparam logic [1:0] FpBefore = 2'd0;
  localparam logic [1:0] FpIn     = 2'd1;
  localparam logic [1:0] FpDone   = 2'd2;
  localparam logic [1:0] FpBad    = 2'd3;

  logic [1:0]                fp_q, fp_d, fp_cur, fp_ent;
  logic [LenW-1:0]           len_q, len_d, len_cur;
  logic                      neg_q, neg_d, neg_cur;
  logic [1:0]                frac_q, frac_d, frac_cur;
  logic [nvsp_pkg::MagW-1:0] mag_q, mag_d, mag_cur;
  logic                      rc_q, rc_d, rc_cur;
  logic                      stop_q, stop_d, stop_cur;
  logic                      is_digit, is_sign, is_dot;
  logic [3:0]                digit;

  always_comb begin
    fp_cur   = first_i ? FpBefore : fp_q;
    len_cur  = first_i ? '0 : len_q;
    neg_cur  = first_i ? 1'b0 : neg_q;
    frac_cur = first_i ? 2'd0 : frac_q;
    mag_cur  = first_i ? '0 : mag_q;
    rc_cur   = first_i ? 1'b0 : rc_q;
    stop_cur = first_i ? 1'b0 : stop_q;

    is_digit = byte_i >= "0" && byte_i <= "9";
    is_sign  = byte_i == "+" || byte_i == "-";
    is_dot   = byte_i == ".";
    digit    = byte_i[3:0];

    // The field opens on the character right after the header.
    fp_ent = (fp_cur == FpBefore && info_i.at_field) ? FpIn : fp_cur;

    fp_d   = fp_ent;
    len_d  = len_cur;
    neg_d  = neg_cur;
    frac_d = frac_cur;
    mag_d  = mag_cur;
    rc_d   = rc_cur;
    stop_d = stop_cur;

    if (fp_ent == FpIn) begin
      if (byte_i == "," || byte_i == "*") begin
        fp_d = FpDone;
      end else if (is_digit || is_sign || is_dot) begin
        // Once conversion stops, legal characters only count toward the length.
        if (!stop_cur) begin
          if (is_sign) begin
            if (len_cur == '0) begin
              neg_d = byte_i == "-";
            end else begin
              stop_d = 1'b1;
            end
          end else if (is_dot) begin
            if (frac_cur == 2'd0) begin
              frac_d = 2'd1;
            end else begin
              stop_d = 1'b1;
            end
          end else begin
            case (frac_cur)
              2'd0: begin
                mag_d = nvsp_pkg::mag_push(mag_cur, digit);
              end
              2'd1: begin
                if (info_i.res) begin
                  mag_d = nvsp_pkg::mag_push(mag_cur, digit);
                end else begin
                  rc_d = digit >= 4'd5;
                end
                frac_d = 2'd2;
              end
              2'd2: begin
                if (info_i.res) rc_d = digit >= 4'd5;
                frac_d = 2'd3;
              end
              default: begin
              end
            endcase
          end
        end
        len_d = len_cur + LenW'(1);
        if (len_d >= LenW'(FIELD_CHARS)) fp_d = FpDone;
      end else begin
        fp_d = FpBad;
      end
    end
  end

  assign sts_o.field_ok    = fp_q == FpDone && len_q != '0;
  assign sts_o.is_neg      = neg_q;
  assign sts_o.frac_count  = frac_q;
  assign sts_o.magnitude   = mag_q;
  assign sts_o.round_carry = rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q   <= FpBefore;
      len_q  <= '0;
      neg_q  <= 1'b0;
      frac_q <= 2'd0;
      mag_q  <= '0;
      rc_q   <= 1'b0;
      stop_q <= 1'b0;
    end else if (step_i) begin
      fp_q   <= fp_d;
      len_q  <= len_d;
      neg_q  <= neg_d;
      frac_q <= frac_d;
      mag_q  <= mag_d;
      rc_q   <= rc_d;
      stop_q <= stop_d;
    end
  end

endmodule

// ----- hdl/nmea_value_sentence_parser_core.sv -----
`timescale 1ns / 1ps
`include "nmea_value_sentence_parser_core_defines.svh"

// Checks one NMEA sentence delivered one character per word and reports the
// first field as a scaled, rounded, range-checked value. A character word can
// be taken in every cycle while input ready is high: the word is captured in
// an input register, the sentence state is updated from it, and a last
// character then produces its result word in the output register. Input
// ready drops only while a result still waits in the output register and the
// next result is already due, so a stalled output side holds at most one
// more result in flight. A sentence restarts at any word that carries
// first_byte.
module nmea_value_sentence_parser_core #(
  parameter int FIELD_CHARS = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nvsp_in_if.sink           in_i,
  nvsp_out_if.source        out_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic [1:0] type_q;
  logic       first_q;
  logic       last_q;
  logic       fin_q;
  logic       adv;
  logic       step;

  logic               out_vld_q;
  logic               valid_res_q;
  logic signed [10:0] value_q;
  logic               resolution_q;
  logic               print_sign_q;

  nvsp_pkg::step_info_t info;
  nvsp_pkg::frame_sts_t frame_sts;
  nvsp_pkg::field_sts_t field_sts;

  logic [nvsp_pkg::MagW-1:0] tot_a;
  logic [nvsp_pkg::MagW:0]   tot_b;
  logic [nvsp_pkg::MagW-1:0] total;
  logic                      res;
  logic                      range_ok;
  logic                      ok;
  logic [10:0]               val_abs;
  logic [10:0]               val;

  assign adv  = !(fin_q && out_vld_q && !out_o.ready);
  assign step = in_vld_q && adv;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      fin_q    <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_i.valid;
      fin_q    <= in_vld_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      byte_q  <= in_i.msg_byte;
      type_q  <= in_i.msg_type;
      first_q <= in_i.first_byte;
      last_q  <= in_i.last_byte;
    end
  end

  nvsp_frame_chk u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (byte_q),
    .type_i  (type_q),
    .first_i (first_q),
    .info_o  (info),
    .sts_o   (frame_sts)
  );

  nvsp_field_conv #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .first_i (first_q),
    .byte_i  (byte_q),
    .info_i  (info),
    .sts_o   (field_sts)
  );

  // Final rounding and range check, read from the state left by the last character.
  always_comb begin
    res   = nvsp_pkg::res_of(frame_sts.kind);
    tot_a = (res && field_sts.frac_count < 2'd2) ?
            nvsp_pkg::mag_push(field_sts.magnitude, 4'd0) : field_sts.magnitude;
    tot_b = {1'b0, tot_a} + {{nvsp_pkg::MagW{1'b0}}, field_sts.round_carry};
    total = tot_b[nvsp_pkg::MagW] ? nvsp_pkg::MagMax : tot_b[nvsp_pkg::MagW-1:0];

    if (field_sts.is_neg) begin
      range_ok = (frame_sts.kind == nvsp_pkg::KindHdt) ? (total == '0) :
                 (total <= nvsp_pkg::MagW'(999));
    end else begin
      range_ok = total <= {6'd0, nvsp_pkg::max_of(frame_sts.kind)};
    end

    ok      = frame_sts.frame_ok && field_sts.field_ok && range_ok;
    val_abs = total[10:0];
    val     = field_sts.is_neg ? (~val_abs + 11'd1) : val_abs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_q && adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q && adv) begin
      valid_res_q  <= ok;
      value_q      <= ok ? $signed(val) : 11'sd0;
      resolution_q <= ok ? res : 1'b0;
      print_sign_q <= ok ? nvsp_pkg::sign_of(frame_sts.kind) : 1'b0;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.valid_res  = valid_res_q;
  assign out_o.value      = value_q;
  assign out_o.resolution = resolution_q;
  assign out_o.print_sign = print_sign_q;

  `NVSP_ASSERT_NXT(a_fin_loads_out, fin_q && adv, out_vld_q, "finished sentence gave no word")
  `NVSP_ASSERT_IMP(a_fail_is_zero, out_vld_q && !valid_res_q,
                   value_q == 11'sd0 && !resolution_q && !print_sign_q, "failed result not zero")
  `NVSP_ASSERT_IMP(a_value_range, out_vld_q && valid_res_q,
                   value_q >= -11'sd999 && value_q <= 11'sd999, "value out of range")
  `NVSP_ASSERT_IMP(a_unsigned_type, out_vld_q && valid_res_q && !print_sign_q,
                   !value_q[10] && !resolution_q, "unsigned type gave a negative value")

endmodule

// ----- tb/nmea_value_sentence_parser_core_test.sv -----
`timescale 1ns / 1ps

module nmea_value_sentence_parser_core_test;

  localparam int FieldChars = 9;

  typedef logic [7:0] char_q_t [$];

  typedef enum logic [2:0] {
    SumWait, SumAcc, SumHex1, SumHex2, SumDone, SumFail
  } sum_phase_e;

  typedef enum logic [1:0] {
    FldBefore, FldIn, FldDone, FldBad
  } fld_phase_e;

  typedef struct {
    nvsp_pkg::kind_t kind;
    logic [7:0]  n_chars;
    logic        hdr_ok;
    logic [15:0] last_two;
    logic        tail_ok;
    sum_phase_e  sum_ph;
    logic [7:0]  xor_acc;
    logic [7:0]  sum_rx;
    fld_phase_e  fld_ph;
    logic [3:0]  fld_len;
    logic        neg;
    logic [1:0]  frac;
    logic [15:0] mag;
    logic        carry;
    logic        stopped;
  } sentence_state_t;

  typedef struct packed {
    logic               ok;
    logic signed [10:0] value;
    logic               scale;
    logic               shows_sign;
  } reading_t;

  string hdr_text [0:2] = '{"$INHDT,", "$PSAG1,", "$VMVBW,"};
  string tail_text [0:2] = '{",T*", "*", ",V*"};
  int len_limit [0:2] = '{21, 17, 31};
  int top_limit [0:2] = '{359, 999, 999};
  int low_limit [0:2] = '{0, -999, -999};

  logic clk;
  logic rst_n;

  sentence_state_t line_state;
  reading_t        pending_readings [$];
  int unsigned     chars_sent;
  int              mismatches;
  int              hold_cycles;
  bit              send_calm;
  bit              recv_calm;

  nvsp_in_if  char_bus ();
  nvsp_out_if reading_bus ();

  nmea_value_sentence_parser_core #(
    .FIELD_CHARS(FieldChars)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (char_bus),
    .out_o (reading_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sentence predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_sentence();
    line_state.kind     = nvsp_pkg::KindHdt;
    line_state.n_chars  = '0;
    line_state.hdr_ok   = 1'b1;
    line_state.last_two = '0;
    line_state.tail_ok  = 1'b0;
    line_state.sum_ph   = SumWait;
    line_state.xor_acc  = '0;
    line_state.sum_rx   = '0;
    line_state.fld_ph   = FldBefore;
    line_state.fld_len  = '0;
    line_state.neg      = 1'b0;
    line_state.frac     = '0;
    line_state.mag      = '0;
    line_state.carry    = 1'b0;
    line_state.stopped  = 1'b0;
  endfunction

  function automatic logic [15:0] push_digit(logic [15:0] m, int d);
    int r;
    r = int'(m) * 10 + d;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  // Decimal conversion of one accepted field character, atof style.
  function automatic void convert_char(logic [7:0] c, logic res);
    int d;
    if (line_state.stopped) return;
    if (c == "+" || c == "-") begin
      if (line_state.fld_len == 0) line_state.neg = (c == "-");
      else line_state.stopped = 1'b1;
    end else if (c == ".") begin
      if (line_state.frac == 0) line_state.frac = 2'd1;
      else line_state.stopped = 1'b1;
    end else begin
      d = int'(c) - 48;
      case (line_state.frac)
        2'd0: line_state.mag = push_digit(line_state.mag, d);
        2'd1: begin
          if (res) line_state.mag = push_digit(line_state.mag, d);
          else line_state.carry = (d >= 5);
          line_state.frac = 2'd2;
        end
        2'd2: begin
          if (res) line_state.carry = (d >= 5);
          line_state.frac = 2'd3;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input nvsp_pkg::kind_t t,
                                     input logic lead, input logic close,
                                     output logic has_res, output reading_t r);
    int   idx;
    int   n;
    int   h;
    int   total;
    int   v;
    logic res;
    logic m;
    logic ok;
    string hs;
    string ts;
    if (lead) begin
      clear_sentence();
      line_state.kind = t;
    end
    idx = int'(line_state.n_chars);
    res = (line_state.kind == nvsp_pkg::KindPsag) || (line_state.kind == nvsp_pkg::KindVbw);

    if (line_state.kind != nvsp_pkg::KindNone) begin
      hs = hdr_text[line_state.kind];
      ts = tail_text[line_state.kind];
      n  = ts.len();
      if (idx < nvsp_pkg::HdrLen && c != hs[idx]) line_state.hdr_ok = 1'b0;
      m = (c == ts[n-1]);
      if (n >= 2 && line_state.last_two[7:0] != ts[n-2]) m = 1'b0;
      if (n >= 3 && line_state.last_two[15:8] != ts[n-3]) m = 1'b0;
      if (m) line_state.tail_ok = 1'b1;
    end

    case (line_state.sum_ph)
      SumWait: if (c == "$") line_state.sum_ph = SumAcc;
      SumAcc: begin
        if (c == "*") line_state.sum_ph = SumHex1;
        else line_state.xor_acc ^= c;
      end
      SumHex1: begin
        h = hex_value(c);
        if (h < 0) line_state.sum_ph = SumFail;
        else begin
          line_state.sum_rx = {h[3:0], 4'h0};
          line_state.sum_ph = SumHex2;
        end
      end
      SumHex2: begin
        h = hex_value(c);
        if (h < 0) line_state.sum_ph = SumFail;
        else begin
          line_state.sum_rx[3:0] = h[3:0];
          line_state.sum_ph = SumDone;
        end
      end
      default: ;
    endcase

    if (line_state.fld_ph == FldBefore && idx == nvsp_pkg::HdrLen) line_state.fld_ph = FldIn;
    if (line_state.fld_ph == FldIn) begin
      if (c == "," || c == "*") begin
        line_state.fld_ph = FldDone;
      end else if ((c >= "0" && c <= "9") || c == "." || c == "-" || c == "+") begin
        convert_char(c, res);
        line_state.fld_len = line_state.fld_len + 4'd1;
        if (line_state.fld_len >= FieldChars) line_state.fld_ph = FldDone;
      end else begin
        line_state.fld_ph = FldBad;
      end
    end

    if (line_state.n_chars != 8'hFF) line_state.n_chars = line_state.n_chars + 8'd1;
    line_state.last_two = {line_state.last_two[7:0], c};

    has_res = close;
    r = '0;
    if (!close) return;

    total = int'(line_state.mag);
    if (res && line_state.frac < 2) total = int'(push_digit(total[15:0], 0));
    total = total + int'(line_state.carry);
    if (total > 65535) total = 65535;

    ok = (line_state.kind != nvsp_pkg::KindNone) && (line_state.sum_ph == SumDone) &&
         (line_state.xor_acc == line_state.sum_rx) && line_state.hdr_ok &&
         line_state.tail_ok && (line_state.fld_ph == FldDone) && (line_state.fld_len != 0);
    if (ok) begin
      ok = (line_state.n_chars <= len_limit[line_state.kind]);
      if (line_state.neg) begin
        if (-total < low_limit[line_state.kind]) ok = 1'b0;
      end else if (total > top_limit[line_state.kind]) begin
        ok = 1'b0;
      end
    end
    if (ok) begin
      v = line_state.neg ? -total : total;
      r.ok         = 1'b1;
      r.value      = v[10:0];
      r.scale      = res;
      r.shows_sign = (line_state.kind != nvsp_pkg::KindHdt);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sentence construction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit lower);
    if (nib < 10) return 8'h30 + nib;
    return (lower ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  function automatic void put_text(ref char_q_t q, input string s);
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Header, field, extra fields and, if keep_tail is set, the tail, closed by '*' and a correct checksum.
  function automatic char_q_t build_line(nvsp_pkg::kind_t k, string field, string extra,
                                         bit lower, bit keep_tail);
    char_q_t    q;
    logic [7:0] x;
    string      tl;
    int         i;
    q = {};
    put_text(q, hdr_text[k]);
    put_text(q, field);
    put_text(q, extra);
    if (keep_tail) begin
      tl = tail_text[k];
      put_text(q, tl.substr(0, tl.len() - 2));
    end
    x = '0;
    for (i = 1; i < q.size(); i++) x ^= q[i];
    q.push_back("*");
    q.push_back(hex_char(x[7:4], lower));
    q.push_back(hex_char(x[3:0], lower));
    return q;
  endfunction

  function automatic string random_field();
    string s;
    string alphabet;
    int    sel;
    alphabet = "0123456789.+-";
    s = "";
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      repeat ($urandom_range(5, 11)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    end else if (sel == 1) begin
      repeat ($urandom_range(0, 10)) s = $sformatf("%s%c", s, alphabet[$urandom_range(0, 12)]);
    end else if (sel == 2) begin
      s = $sformatf("%0d%c%0d", $urandom_range(0, 99), 8'h41 + $urandom_range(0, 25),
                    $urandom_range(0, 9));
    end else begin
      case ($urandom_range(0, 3))
        0: s = "-";
        1: s = "+";
        default: s = "";
      endcase
      repeat ($urandom_range(0, 3)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      if ($urandom_range(0, 3) != 0) begin
        s = {s, "."};
        repeat ($urandom_range(0, 3)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      end
    end
    return s;
  endfunction

  function automatic char_q_t random_line(nvsp_pkg::kind_t k);
    char_q_t q;
    string   f;
    string   extra;
    int      pos;
    extra = "";
    f = random_field();
    if (k == nvsp_pkg::KindVbw) begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1) == 0) extra = $sformatf("%s,%0d", extra, $urandom_range(0, 99));
        else extra = {extra, ",A"};
      end
    end
    q = build_line(k, f, extra, $urandom_range(0, 1) == 1, $urandom_range(0, 19) != 0);
    // A NUL leaves the checksum untouched, so it lands inside the extra fields.
    pos = nvsp_pkg::HdrLen + f.len() + 1;
    if (extra != "" && pos < q.size() && $urandom_range(0, 5) == 0) q.insert(pos, 8'h00);
    if ($urandom_range(0, 24) == 0) q[$urandom_range(1, 6)] = 8'h41 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 19) == 0) q[q.size()-1] = hex_char(4'($urandom_range(0, 15)), 1'b0);
    if ($urandom_range(0, 29) == 0) q[q.size()-2] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 14) == 0) begin
      q.push_back(8'h0D);
      q.push_back(8'h0A);
    end
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 3)) q.push_front(8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver and result checker
  // ---------------------------------------------------------------------------

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_char(input logic [7:0] c, input nvsp_pkg::kind_t t, input logic lead,
                           input logic close);
    int       gap;
    logic     has_res;
    reading_t r;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_bus.valid      <= 1'b1;
    char_bus.msg_byte   <= c;
    char_bus.msg_type   <= t;
    char_bus.first_byte <= lead;
    char_bus.last_byte  <= close;
    do @(posedge clk); while (!char_bus.ready);
    parse_char(c, t, lead, close, has_res, r);
    if (has_res) pending_readings.push_back(r);
    chars_sent++;
  endtask

  task automatic send_line(input char_q_t q, input nvsp_pkg::kind_t t, input bit lead,
                           input bit close);
    int i;
    for (i = 0; i < q.size(); i++) send_char(q[i], t, lead && i == 0, close && i == q.size() - 1);
  endtask

  task automatic check_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      report_mismatch("result word arrived with no sentence end pending");
      return;
    end
    want = pending_readings.pop_front();
    if (reading_bus.valid_res !== want.ok)
      report_mismatch($sformatf("valid_res got %b want %b", reading_bus.valid_res, want.ok));
    if (reading_bus.value !== want.value)
      report_mismatch($sformatf("value got %0d want %0d", reading_bus.value, want.value));
    if (reading_bus.resolution !== want.scale)
      report_mismatch($sformatf("resolution got %b want %b", reading_bus.resolution,
                                want.scale));
    if (reading_bus.print_sign !== want.shows_sign)
      report_mismatch($sformatf("print_sign got %b want %b", reading_bus.print_sign,
                                want.shows_sign));
  endtask

  // Result side: random stalls after each word, plus a long hold-off on request.
  initial begin : result_sink
    int stall;
    stall = 0;
    reading_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        reading_bus.ready <= 1'b0;
        continue;
      end
      if (reading_bus.valid && reading_bus.ready) begin
        check_reading();
        stall = draw_wait(recv_calm);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        reading_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        reading_bus.ready <= 1'b0;
      end else begin
        reading_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic send_value(input nvsp_pkg::kind_t k, input string field);
    send_line(build_line(k, field, "", 1'b0, 1'b1), k, 1'b1, 1'b1);
  endtask

  task automatic test_field_values();
    send_value(nvsp_pkg::KindHdt, "359");
    send_value(nvsp_pkg::KindHdt, "359.5");
    send_value(nvsp_pkg::KindHdt, "-0");
    send_value(nvsp_pkg::KindHdt, "-1");
    send_value(nvsp_pkg::KindPsag, "99.94");
    send_value(nvsp_pkg::KindPsag, "-99.95");
    send_value(nvsp_pkg::KindPsag, "+1.25");
    send_value(nvsp_pkg::KindPsag, ".");
    send_value(nvsp_pkg::KindPsag, "");
    send_value(nvsp_pkg::KindPsag, "-");
    send_value(nvsp_pkg::KindVbw, "1.2.3");
    send_value(nvsp_pkg::KindVbw, "12-3");
    send_value(nvsp_pkg::KindVbw, "123456789");
    // Only the first nine field characters are looked at.
    send_value(nvsp_pkg::KindVbw, "12345678901");
    send_value(nvsp_pkg::KindVbw, "1a");
    send_value(nvsp_pkg::KindVbw, "0.05");
  endtask

  task automatic test_framing_checks();
    char_q_t q;
    q = build_line(nvsp_pkg::KindHdt, "123", "", 1'b1, 1'b1);
    q.push_back(8'h0D);
    q.push_back(8'h0A);
    send_line(q, nvsp_pkg::KindHdt, 1'b1, 1'b1);

    q = build_line(nvsp_pkg::KindPsag, "5", "", 1'b0, 1'b1);
    q[q.size()-1] = (q[q.size()-1] == "0") ? "1" : "0";
    send_line(q, nvsp_pkg::KindPsag, 1'b1, 1'b1);

    q = build_line(nvsp_pkg::KindPsag, "5", "", 1'b0, 1'b1);
    q[q.size()-2] = "G";
    send_line(q, nvsp_pkg::KindPsag, 1'b1, 1'b1);

    send_line(build_line(nvsp_pkg::KindVbw, "1.5", "", 1'b0, 1'b1), nvsp_pkg::KindNone,
              1'b1, 1'b1);

    q = build_line(nvsp_pkg::KindHdt, "90", "", 1'b0, 1'b1);
    q.push_front(8'hA4);
    q.push_front("x");
    send_line(q, nvsp_pkg::KindHdt, 1'b1, 1'b1);

    q = build_line(nvsp_pkg::KindHdt, "1", "", 1'b0, 1'b1);
    send_line(q[0:2], nvsp_pkg::KindHdt, 1'b1, 1'b1);

    q = build_line(nvsp_pkg::KindVbw, "4.5", ",A,B", 1'b0, 1'b1);
    q.insert(11, 8'h00);
    send_line(q, nvsp_pkg::KindVbw, 1'b1, 1'b1);

    // Without first_byte the characters extend the sentence already held.
    send_line(build_line(nvsp_pkg::KindPsag, "2", "", 1'b0, 1'b1), nvsp_pkg::KindPsag,
              1'b0, 1'b1);

    send_line(build_line(nvsp_pkg::KindHdt, "45", "", 1'b0, 1'b0), nvsp_pkg::KindHdt,
              1'b1, 1'b1);
    send_line(build_line(nvsp_pkg::KindVbw, "1.0", ",1,2,3,4,5,6,7,8,9,10", 1'b0, 1'b1),
              nvsp_pkg::KindVbw, 1'b1, 1'b1);

    q = build_line(nvsp_pkg::KindVbw, "7", "", 1'b0, 1'b1);
    send_line(q[0:5], nvsp_pkg::KindVbw, 1'b1, 1'b0);
    send_line(build_line(nvsp_pkg::KindVbw, "8.25", "", 1'b0, 1'b1), nvsp_pkg::KindVbw,
              1'b1, 1'b1);
  endtask

  // The result side holds off while sentences keep coming, so the block has
  // to stop taking characters until the hold-off ends.
  task automatic test_output_stall();
    nvsp_pkg::kind_t k;
    send_calm = 1'b1;
    recv_calm = 1'b1;
    hold_cycles = 300;
    repeat (30) begin
      k = nvsp_pkg::kind_t'($urandom_range(0, 2));
      send_line(build_line(k, random_field(), "", 1'b0, 1'b1), k, 1'b1, 1'b1);
    end
    repeat (20) send_char("7", nvsp_pkg::KindPsag, 1'b1, 1'b1);
    send_calm = 1'b0;
    recv_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned     target;
    char_q_t         q;
    nvsp_pkg::kind_t k;
    nvsp_pkg::kind_t t;
    // The directed tests above already used part of the character budget.
    target = 1650;
    while (chars_sent < target) begin
      if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      if ($urandom_range(0, 99) < 6) begin
        repeat ($urandom_range(1, 24))
          send_char(8'($urandom_range(0, 255)), nvsp_pkg::kind_t'($urandom_range(0, 3)),
                    $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
      end else begin
        k = nvsp_pkg::kind_t'($urandom_range(0, 2));
        t = ($urandom_range(0, 24) == 0) ? nvsp_pkg::kind_t'($urandom_range(0, 3)) : k;
        q = random_line(k);
        if ($urandom_range(0, 29) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
        send_line(q, t, $urandom_range(0, 29) != 0, $urandom_range(0, 29) != 0);
      end
    end
  endtask

  initial begin : stimulus
    rst_n               <= 1'b0;
    char_bus.valid      <= 1'b0;
    char_bus.msg_byte   <= '0;
    char_bus.msg_type   <= nvsp_pkg::KindHdt;
    char_bus.first_byte <= 1'b0;
    char_bus.last_byte  <= 1'b0;
    chars_sent  = 0;
    mismatches  = 0;
    hold_cycles = 0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    clear_sentence();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_values();
    test_framing_checks();
    test_output_stall();
    test_random_traffic();

    char_bus.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/nvsp_pkg.sv
hdl/nvsp_if.sv
hdl/nvsp_frame_chk.sv
hdl/nvsp_field_conv.sv
hdl/nmea_value_sentence_parser_core.sv
tb/nmea_value_sentence_parser_core_test.sv
